[src/polygon_winding_number_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef POLYGON_WINDING_NUMBER_MACROS_SVH
`define POLYGON_WINDING_NUMBER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWN_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("polygon winding number: check failed");

// The consequent must hold in the cycle after the antecedent.
`define PWN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("polygon winding number: check failed");

`endif

[src/pwn_pkg.sv]
package pwn_pkg;

   localparam int VINDEX_W = 10;
   localparam int ROWS_W   = 11;
   localparam int WIND_W   = 11;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic busy;
      logic inc;
      logic dec;
   } edge_status_type;

endpackage

[src/pwn_edge.sv]
module pwn_edge import pwn_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] x0,
   input  logic signed [COORD_BITS-1:0] y0,
   input  logic signed [COORD_BITS-1:0] x1,
   input  logic signed [COORD_BITS-1:0] y1,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output edge_status_type              status
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] dx_ff, dyp_ff, dxp_ff, dy_ff;
   logic                 up_ff, down_ff, va_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic                 up2_ff, down2_ff, vb_ff;

   logic signed [PW-1:0] p1_in, p2_in;

   assign p1_in = PW'(dx_ff) * PW'(dyp_ff);
   assign p2_in = PW'(dxp_ff) * PW'(dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= DW'(x1) - DW'(x0);
      dyp_ff   <= DW'(py) - DW'(y0);
      dxp_ff   <= DW'(px) - DW'(x0);
      dy_ff    <= DW'(y1) - DW'(y0);
      up_ff    <= (y0 <= py) && (y1 > py);
      down_ff  <= (y0 > py) && (y1 <= py);
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      up2_ff   <= up_ff;
      down2_ff <= down_ff;
   end

   always_comb begin
      status.busy  = va_ff || vb_ff;
      status.inc   = vb_ff && up2_ff && (p1_ff > p2_ff);
      status.dec   = vb_ff && down2_ff && (p1_ff < p2_ff);
   end

endmodule

[src/polygon_winding_number.sv]
// Winding-number point-in-polygon test. A write word stores one polygon point
// in the vertex memory; the polygon must be closed, so the last of the
// csr_wr_data points repeats the first. A query word walks the edges between
// consecutive stored points and answers with the signed winding number and an
// inside flag. The single read port of the vertex memory hands out one point
// per cycle; when the csr_wr_data row count is zero, the answer is one.
// Every point that a query reads must have been written since reset.
module polygon_winding_number import pwn_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [VINDEX_W-1:0]          req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [WIND_W-1:0]     rsp_winding,
   output logic                         rsp_inside_res,
   input  logic                         csr_wr_en,
   input  logic [ROWS_W-1:0]            csr_wr_data
);

   localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int RW   = (CNTW > ROWS_W) ? CNTW : ROWS_W;
   localparam int IW   = (AW > VINDEX_W) ? AW : VINDEX_W;
   localparam int MW   = 2 * COORD_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_type;

   state_type                    state_ff;
   logic [ROWS_W-1:0]            rows_cfg_ff;
   logic [RW-1:0]                rows_ff, cnt_ff;
   logic                         rd_valid_ff, rd_first_ff;
   logic [MW-1:0]                rd_data_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff, px_ff, py_ff;
   logic signed [WIND_W-1:0]     wn_ff, wn_in;
   logic                         rsp_valid_ff, rsp_inside_ff;
   logic signed [WIND_W-1:0]     rsp_winding_ff;

   logic [MW-1:0]                vertex_mem [MAX_VERTICES];

   logic [RW-1:0]                rows_sat;
   logic [IW-1:0]                wr_idx;
   logic                         req_fire, wr_en, rd_en, walk_done;
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   edge_status_type              edge_st;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rows_sat  = (RW'(rows_cfg_ff) > RW'(MAX_VERTICES)) ? RW'(MAX_VERTICES)
                                                             : RW'(rows_cfg_ff);
   assign wr_idx    = IW'(req_vertex_index);
   assign wr_en     = req_fire && (req_action == ACTION_WRITE) &&
                      (RW'(req_vertex_index) < RW'(MAX_VERTICES));
   assign rd_en     = (state_ff == ST_WALK) && (cnt_ff < rows_ff);
   assign walk_done = (state_ff == ST_WALK) && !rd_en && !rd_valid_ff && !edge_st.busy;
   assign cur_x     = rd_data_ff[MW-1:COORD_BITS];
   assign cur_y     = rd_data_ff[COORD_BITS-1:0];
   assign wn_in     = wn_ff + WIND_W'(edge_st.inc) - WIND_W'(edge_st.dec);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_winding    = rsp_winding_ff;
   assign rsp_inside_res = rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem[wr_idx[AW-1:0]] <= {req_coord_x, req_coord_y};
      end
      if (rd_en) begin
         rd_data_ff <= vertex_mem[cnt_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_action == ACTION_QUERY)) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
      if (rd_valid_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
   end

   pwn_edge #(
      .COORD_BITS(COORD_BITS)
   ) u_edge (
      .clock   (clock),
      .reset   (reset),
      .in_valid(rd_valid_ff && !rd_first_ff),
      .x0      (prev_x_ff),
      .y0      (prev_y_ff),
      .x1      (cur_x),
      .y1      (cur_y),
      .px      (px_ff),
      .py      (py_ff),
      .status  (edge_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_cfg_ff  <= '0;
         rows_ff      <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_first_ff  <= 1'b0;
         wn_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rows_cfg_ff <= csr_wr_data;
         end
         rd_valid_ff <= rd_en;
         rd_first_ff <= (cnt_ff == '0);
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_action == ACTION_QUERY)) begin
                  cnt_ff  <= '0;
                  rows_ff <= rows_sat;
                  if (rows_sat == '0) begin
                     wn_ff    <= WIND_W'(1);
                     state_ff <= ST_FINISH;
                  end else begin
                     wn_ff    <= '0;
                     state_ff <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               if (rd_en) begin
                  cnt_ff <= cnt_ff + RW'(1);
               end
               wn_ff <= wn_in;
               if (walk_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_winding_ff <= wn_ff;
                  rsp_inside_ff  <= (wn_ff != '0);
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[src/pwn_check.sv]
`include "polygon_winding_number_macros.svh"

module pwn_check import pwn_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_action,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [WIND_W-1:0] rsp_winding,
   input logic                     rsp_inside_res
);

   logic wr_fire, query_fire;

   assign wr_fire    = req_valid && req_ready && (req_action == ACTION_WRITE);
   assign query_fire = req_valid && req_ready && (req_action == ACTION_QUERY);

   `PWN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PWN_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_winding))
   `PWN_ASSERT_SAME(a_inside_flag, clock, reset, rsp_valid, rsp_inside_res == (rsp_winding != '0))
   `PWN_ASSERT_NEXT(a_write_silent, clock, reset, wr_fire && !rsp_valid, !rsp_valid)
   `PWN_ASSERT_NEXT(a_query_busy, clock, reset, query_fire, !req_ready)

endmodule

bind polygon_winding_number pwn_check u_pwn_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_winding   (rsp_winding),
   .rsp_inside_res(rsp_inside_res)
);
